[hdl/spta_pkg.sv]
// spta_pkg: shared types and codes for the sparse polynomial term accumulator
// used by spta_ctrl, spta_datapath and sparse_polynomial_term_accumulator_top
// no dependencies
`default_nettype none

package spta_pkg;

  localparam int DEFAULT_MAX_TERMS = 32;

  localparam int COEF_W = 32;
  localparam int EXP_W  = 64;
  localparam int STAT_W = 2;

  // input item kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_DRAIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic cmp;
    logic update;
    logic drain_pop;
    logic drain_empty;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic count_zero;
    logic count_one;
  } sts_t;

endpackage

`default_nettype wire

[hdl/spta_ctrl.sv]
// spta_ctrl: sequencer for add and drain items
// depends on spta_pkg
`default_nettype none

module spta_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  input  wire                    in_kind,
  output logic                   in_ready,
  input  wire spta_pkg::sts_t    sts,
  output spta_pkg::cmd_t         cmd
);

  spta_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spta_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      spta_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = (in_kind == spta_pkg::KIND_DRAIN) ? spta_pkg::S_DRAIN
                                                          : spta_pkg::S_CMP;
        end
      end
      spta_pkg::S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = spta_pkg::S_UPD;
      end
      spta_pkg::S_UPD: begin
        if (sts.out_free) begin
          cmd.update = 1'b1;
          state_nxt  = spta_pkg::S_IDLE;
        end
      end
      spta_pkg::S_DRAIN: begin
        if (sts.out_free) begin
          if (sts.count_zero) begin
            cmd.drain_empty = 1'b1;
            state_nxt       = spta_pkg::S_IDLE;
          end else begin
            cmd.drain_pop = 1'b1;
            if (sts.count_one) begin
              state_nxt = spta_pkg::S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = spta_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/spta_datapath.sv]
// spta_datapath: sorted term cell chain, compare flags and result register
// depends on spta_pkg
`default_nettype none

module spta_datapath #(
  parameter int MAX_TERMS = spta_pkg::DEFAULT_MAX_TERMS
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire spta_pkg::cmd_t                   cmd,
  output spta_pkg::sts_t                        sts,
  input  wire signed [spta_pkg::COEF_W-1:0]     in_coefficient,
  input  wire signed [spta_pkg::EXP_W-1:0]      in_exponent,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [spta_pkg::COEF_W-1:0]    out_term_coefficient,
  output logic signed [spta_pkg::EXP_W-1:0]     out_term_exponent,
  output logic [spta_pkg::STAT_W-1:0]           out_status,
  output logic                                  out_last
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int N  = MAX_TERMS;

  // latched add operands
  logic signed [spta_pkg::COEF_W-1:0] coef_r;
  logic signed [spta_pkg::EXP_W-1:0]  exp_r;

  // term cells, cell 0 holds the highest exponent
  logic signed [spta_pkg::COEF_W-1:0] cell_coef_r [N];
  logic signed [spta_pkg::EXP_W-1:0]  cell_exp_r  [N];
  logic signed [spta_pkg::COEF_W-1:0] cell_coef_nxt [N];
  logic signed [spta_pkg::EXP_W-1:0]  cell_exp_nxt  [N];
  logic [CW-1:0]                      count_r, count_nxt;

  // per-cell compare flags, gt is a prefix because cells are sorted
  logic [N-1:0] gt_r, eq_r, gt_nxt, eq_nxt, zero_sum;
  logic signed [spta_pkg::COEF_W-1:0] sum [N];

  logic any_eq, removed, full;

  // result register
  logic                                out_valid_r, out_valid_nxt;
  logic signed [spta_pkg::COEF_W-1:0]  out_coef_r, out_coef_nxt;
  logic signed [spta_pkg::EXP_W-1:0]   out_exp_r, out_exp_nxt;
  logic [spta_pkg::STAT_W-1:0]         out_status_r, out_status_nxt;
  logic                                out_last_r, out_last_nxt;

  assign any_eq  = |eq_r;
  assign removed = |(eq_r & zero_sum);
  assign full    = (count_r == CW'(N));

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.count_zero = (count_r == '0);
  assign sts.count_one  = (count_r == CW'(1));

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic signed [spta_pkg::COEF_W-1:0] up_coef, dn_coef;
      logic signed [spta_pkg::EXP_W-1:0]  up_exp, dn_exp;
      logic                               gt_prev, valid;

      if (gi == N - 1) begin : g_top
        assign up_coef = '0;
        assign up_exp  = '0;
      end else begin : g_mid
        assign up_coef = cell_coef_r[gi+1];
        assign up_exp  = cell_exp_r[gi+1];
      end

      if (gi == 0) begin : g_first
        assign dn_coef = '0;
        assign dn_exp  = '0;
        assign gt_prev = 1'b1;
      end else begin : g_rest
        assign dn_coef = cell_coef_r[gi-1];
        assign dn_exp  = cell_exp_r[gi-1];
        assign gt_prev = gt_r[gi-1];
      end

      assign valid       = (count_r > CW'(gi));
      assign gt_nxt[gi]  = valid && (cell_exp_r[gi] > exp_r);
      assign eq_nxt[gi]  = valid && (cell_exp_r[gi] == exp_r);
      assign sum[gi]     = cell_coef_r[gi] + coef_r;
      assign zero_sum[gi] = (sum[gi] == '0);

      always_comb begin
        cell_coef_nxt[gi] = cell_coef_r[gi];
        cell_exp_nxt[gi]  = cell_exp_r[gi];
        if (cmd.drain_pop) begin
          cell_coef_nxt[gi] = up_coef;
          cell_exp_nxt[gi]  = up_exp;
        end else if (cmd.update) begin
          if (any_eq) begin
            if (removed) begin
              // close the gap at and after the matched term
              if (!gt_r[gi]) begin
                cell_coef_nxt[gi] = up_coef;
                cell_exp_nxt[gi]  = up_exp;
              end
            end else if (eq_r[gi]) begin
              cell_coef_nxt[gi] = sum[gi];
            end
          end else if (!full) begin
            if (!gt_r[gi] && gt_prev) begin
              cell_coef_nxt[gi] = coef_r;
              cell_exp_nxt[gi]  = exp_r;
            end else if (!gt_prev) begin
              cell_coef_nxt[gi] = dn_coef;
              cell_exp_nxt[gi]  = dn_exp;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        cell_coef_r[gi] <= cell_coef_nxt[gi];
        cell_exp_r[gi]  <= cell_exp_nxt[gi];
      end
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.drain_pop) begin
      count_nxt = count_r - CW'(1);
    end else if (cmd.update) begin
      if (any_eq && removed) begin
        count_nxt = count_r - CW'(1);
      end else if (!any_eq && !full) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_coef_nxt   = out_coef_r;
    out_exp_nxt    = out_exp_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (cmd.update) begin
      out_valid_nxt  = 1'b1;
      out_coef_nxt   = '0;
      out_exp_nxt    = '0;
      out_status_nxt = (!any_eq && full) ? spta_pkg::ST_FULL : spta_pkg::ST_OK;
      out_last_nxt   = 1'b1;
    end else if (cmd.drain_pop) begin
      out_valid_nxt  = 1'b1;
      out_coef_nxt   = cell_coef_r[0];
      out_exp_nxt    = cell_exp_r[0];
      out_status_nxt = spta_pkg::ST_OK;
      out_last_nxt   = (count_r == CW'(1));
    end else if (cmd.drain_empty) begin
      out_valid_nxt  = 1'b1;
      out_coef_nxt   = '0;
      out_exp_nxt    = '0;
      out_status_nxt = spta_pkg::ST_EMPTY;
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      coef_r <= in_coefficient;
      exp_r  <= in_exponent;
    end
    if (cmd.cmp) begin
      gt_r <= gt_nxt;
      eq_r <= eq_nxt;
    end
    out_coef_r   <= out_coef_nxt;
    out_exp_r    <= out_exp_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_term_coefficient = out_coef_r;
  assign out_term_exponent    = out_exp_r;
  assign out_status           = out_status_r;
  assign out_last             = out_last_r;

endmodule

`default_nettype wire

[hdl/sparse_polynomial_term_accumulator_top.sv]
// sparse_polynomial_term_accumulator_top: sorted polynomial term store
// instantiates spta_ctrl and spta_datapath, depends on spta_pkg
//
// channel   direction  handshake               payload
// in_       input      in_valid / in_ready     kind, coefficient, exponent
// out_      output     out_valid / out_ready   term_coefficient, term_exponent,
//                                              status, last
//
// an add item holds the block while it runs: the accept latches the operands,
// then the compare state latches compares against all stored exponents in parallel,
// and the update state runs one cell chain update and registers its result
// a drain item gives one result per stored term, one per cycle while the
// result register is being taken, or a single empty result when none is stored
// in_ready is high only while no item is in work; a result held in the
// output register stalls the update or drain step until it is taken
// reset clears the term count and the output valid; term cells need no reset
`default_nettype none

module sparse_polynomial_term_accumulator_top #(
  parameter int MAX_TERMS = spta_pkg::DEFAULT_MAX_TERMS
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 in_kind,
  input  wire signed [spta_pkg::COEF_W-1:0]   in_coefficient,
  input  wire signed [spta_pkg::EXP_W-1:0]    in_exponent,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [spta_pkg::COEF_W-1:0]  out_term_coefficient,
  output logic signed [spta_pkg::EXP_W-1:0]   out_term_exponent,
  output logic [spta_pkg::STAT_W-1:0]         out_status,
  output logic                                out_last
);

  // command and status between sequencer and cell chain
  spta_pkg::cmd_t cmd;
  spta_pkg::sts_t sts;

  spta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spta_datapath #(
    .MAX_TERMS (MAX_TERMS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_coefficient       (in_coefficient),
    .in_exponent          (in_exponent),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_term_coefficient (out_term_coefficient),
    .out_term_exponent    (out_term_exponent),
    .out_status           (out_status),
    .out_last             (out_last)
  );

endmodule

`default_nettype wire

[verif/tb_sparse_polynomial_term_accumulator_top.sv]
// testbench for sparse_polynomial_term_accumulator_top: random and directed term items,
// self-checking against a sorted term store kept in the testbench
// depends on spta_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_sparse_polynomial_term_accumulator_top;

  localparam int TERM_SLOTS   = spta_pkg::DEFAULT_MAX_TERMS;
  localparam int ITEM_TARGET  = 420;
  localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake on either side
  localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
  localparam int HOLD_AT_ITEM = 60;
  localparam int CALM_FROM    = 150;   // no random idling on either side in this item window
  localparam int CALM_TO      = 240;

  // one input item as queued for the driver
  typedef struct packed {
    logic                        kind;
    logic [spta_pkg::COEF_W-1:0] coef;
    logic [spta_pkg::EXP_W-1:0]  expo;
    logic                        hold;   // sender waits for every awaited term first
  } term_item_t;

  // one result item as the block should emit it
  typedef struct packed {
    logic [spta_pkg::COEF_W-1:0] coef;
    logic [spta_pkg::EXP_W-1:0]  expo;
    logic [spta_pkg::STAT_W-1:0] status;
    logic                        last;
  } term_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               in_kind = spta_pkg::KIND_ADD;
  logic signed [spta_pkg::COEF_W-1:0] in_coefficient = '0;
  logic signed [spta_pkg::EXP_W-1:0]  in_exponent = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [spta_pkg::COEF_W-1:0] out_term_coefficient;
  logic signed [spta_pkg::EXP_W-1:0]  out_term_exponent;
  logic [spta_pkg::STAT_W-1:0]        out_status;
  logic                               out_last;

  // stimulus side
  term_item_t   item_q[$];
  logic [31:0]  planned_sums[longint];  // terms the generator expects to be stored
  int           items_taken = 0;
  logic         in_took = 1'b0;

  // predictor side: the term store as the block should hold it
  logic [spta_pkg::COEF_W-1:0]        store_coef[TERM_SLOTS];
  logic signed [spta_pkg::EXP_W-1:0]  store_exp[TERM_SLOTS];
  int                                 store_count = 0;
  term_result_t                       awaited_terms[$];

  int  error_count = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  quiet_cycles = 0;

  wire calm = (items_taken >= CALM_FROM) && (items_taken < CALM_TO);

  sparse_polynomial_term_accumulator_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_coefficient       (in_coefficient),
    .in_exponent          (in_exponent),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_term_coefficient (out_term_coefficient),
    .out_term_exponent    (out_term_exponent),
    .out_status           (out_status),
    .out_last             (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // term store prediction, run once per accepted input item
  // ---------------------------------------------------------------------------
  task automatic apply_term_item(input logic kind, input logic [spta_pkg::COEF_W-1:0] c,
                                 input logic signed [spta_pkg::EXP_W-1:0] e);
    int                          pos;
    int                          i;
    logic [spta_pkg::COEF_W-1:0] sum;
    term_result_t                r;
    r = '0;
    r.last = 1'b1;
    r.status = spta_pkg::ST_OK;
    if (kind == spta_pkg::KIND_ADD) begin
      // stored terms run in strictly descending signed exponent order
      pos = 0;
      while (pos < store_count && store_exp[pos] > e) pos++;
      if (pos < store_count && store_exp[pos] == e) begin
        // merge even when the store is full, no new slot is needed
        sum = store_coef[pos] + c;
        if (sum == '0) begin
          // cancelled term leaves the store, the tail closes up
          for (i = pos; i + 1 < store_count; i++) begin
            store_coef[i] = store_coef[i + 1];
            store_exp[i]  = store_exp[i + 1];
          end
          store_count--;
        end else begin
          store_coef[pos] = sum;
        end
      end else if (store_count >= TERM_SLOTS) begin
        r.status = spta_pkg::ST_FULL;  // new exponent with no room, nothing changes
      end else begin
        // zero coefficient still gets a slot
        for (i = store_count; i > pos; i--) begin
          store_coef[i] = store_coef[i - 1];
          store_exp[i]  = store_exp[i - 1];
        end
        store_coef[pos] = c;
        store_exp[pos]  = e;
        store_count++;
      end
      awaited_terms.push_back(r);
    end else if (store_count == 0) begin
      r.status = spta_pkg::ST_EMPTY;
      awaited_terms.push_back(r);
    end else begin
      for (i = 0; i < store_count; i++) begin
        r.coef = store_coef[i];
        r.expo = store_exp[i];
        r.last = (i + 1 == store_count);
        awaited_terms.push_back(r);
      end
      store_count = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus planning, tracks the store contents to aim cancels and fills
  // ---------------------------------------------------------------------------
  task automatic plan_add(input logic [spta_pkg::COEF_W-1:0] c,
                          input logic [spta_pkg::EXP_W-1:0] e, input logic hold);
    longint      k;
    logic [31:0] sum;
    k = e;
    if (planned_sums.exists(k)) begin
      sum = planned_sums[k] + c;
      if (sum == 0) planned_sums.delete(k);
      else planned_sums[k] = sum;
    end else if (planned_sums.num() < TERM_SLOTS) begin
      planned_sums[k] = c;
    end
    item_q.push_back('{kind: spta_pkg::KIND_ADD, coef: c, expo: e, hold: hold});
  endtask

  // payload of a drain is don't-care, so it carries random bits
  task automatic plan_drain(input logic hold);
    planned_sums.delete();
    item_q.push_back('{kind: spta_pkg::KIND_DRAIN, coef: $urandom,
                       expo: {$urandom, $urandom}, hold: hold});
  endtask

  // ---------------------------------------------------------------------------
  // driver: payload changes at the falling edge, held until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_items
    term_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (item_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (item_q[0].hold && awaited_terms.size() != 0) begin
        in_valid <= 1'b0;  // pause until the block has emitted everything
      end else if (!calm && $urandom_range(0, 99) < 18) begin
        in_valid <= 1'b0;
      end else begin
        nxt = item_q.pop_front();
        in_valid       <= 1'b1;
        in_kind        <= nxt.kind;
        in_coefficient <= nxt.coef;
        in_exponent    <= nxt.expo;
      end
    end
  end

  // receiver: random stalls, one long hold-off counted here
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= HOLD_AT_ITEM) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 18);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    term_result_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        apply_term_item(in_kind, in_coefficient, in_exponent);
        items_taken++;
      end
      if (out_valid && out_ready) begin
        if (awaited_terms.size() == 0) begin
          report_mismatch("unexpected result", 64'({out_status, 3'b0, out_last}), '0);
        end else begin
          want = awaited_terms.pop_front();
          if (out_term_coefficient !== want.coef)
            report_mismatch("term_coefficient", 64'($unsigned(out_term_coefficient)),
                            64'(want.coef));
          if (out_term_exponent !== want.expo)
            report_mismatch("term_exponent", out_term_exponent, want.expo);
          if (out_status !== want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_last !== want.last)
            report_mismatch("last", 64'(out_last), 64'(want.last));
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan and end of run
  // ---------------------------------------------------------------------------
  initial begin : run_plan
    logic [spta_pkg::EXP_W-1:0]  pool[10];
    logic [spta_pkg::COEF_W-1:0] c;
    logic [spta_pkg::EXP_W-1:0]  e;
    longint                      k;
    int                          pick;
    int                          n;
    int                          j;
    int                          total;
    bit                          first_seq;

    // directed: empty drain, extreme fields, wrap, cancels, zero-coefficient insert
    plan_drain(1'b0);
    plan_add(32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff, 1'b0);
    plan_add(32'h8000_0000, 64'h8000_0000_0000_0000, 1'b0);
    plan_add(32'h0000_0000, 64'h0, 1'b0);
    plan_add(32'h0000_0001, 64'h7fff_ffff_ffff_ffff, 1'b0);  // wraps to most negative
    plan_add(32'h8000_0000, 64'h8000_0000_0000_0000, 1'b0);  // sum wraps to zero
    plan_add(32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0);
    plan_add(32'h0000_0005, 64'h0, 1'b0);                     // merge into a zero term
    plan_add(32'hffff_fffb, 64'h0, 1'b0);                     // and cancel it
    plan_add(32'h0000_0003, 64'h1, 1'b0);
    plan_drain(1'b0);
    plan_drain(1'b0);

    first_seq = 1'b1;
    pool[0] = 64'h7fff_ffff_ffff_ffff;
    pool[1] = 64'h8000_0000_0000_0000;
    pool[2] = 64'h0;
    pool[3] = 64'hffff_ffff_ffff_ffff;
    pool[4] = 64'h1;
    while (item_q.size() < ITEM_TARGET) begin
      for (j = 5; j < 10; j++) pool[j] = {$urandom, $urandom};
      pick = first_seq ? 6 : $urandom_range(0, 9);
      case (pick)
        6, 7: begin
          // fill the store, push past it, merge while full, then drain it all
          while (planned_sums.num() < TERM_SLOTS) begin
            plan_add($urandom, {$urandom, $urandom}, first_seq);
            first_seq = 1'b0;
          end
          n = $urandom_range(1, 3);
          for (j = 0; j < n; j++) plan_add($urandom, {$urandom, $urandom}, 1'b0);
          void'(planned_sums.first(k));
          plan_add($urandom_range(1, 9), k, 1'b0);
          plan_drain(1'($urandom_range(0, 1)));
        end
        8: begin
          plan_drain($urandom_range(0, 3) == 0);
        end
        9: begin
          // noise: any kind, any field values
          n = $urandom_range(3, 8);
          for (j = 0; j < n; j++) begin
            if ($urandom_range(0, 1)) plan_drain(1'b0);
            else plan_add($urandom, {$urandom, $urandom}, 1'b0);
          end
        end
        default: begin
          // few exponents, so merges and cancels are frequent
          n = $urandom_range(4, 16);
          for (j = 0; j < n; j++) begin
            e = pool[$urandom_range(0, 9)];
            k = e;
            case ($urandom_range(0, 3))
              0: c = planned_sums.exists(k) ? -planned_sums[k] : $urandom;
              1: c = $urandom_range(0, 20) - 10;
              2: c = $urandom;
              default: c = '0;
            endcase
            plan_add(c, e, (j == 0) && ($urandom_range(0, 3) == 0));
          end
          if ($urandom_range(0, 1)) plan_drain(1'b0);
        end
      endcase
    end
    total = item_q.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (items_taken < total) @(negedge clk);
    while (awaited_terms.size() != 0) @(negedge clk);
    // an add result is registered after the compare and update states; leave room for anything stray
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (awaited_terms.size() != 0)
      report_mismatch("results never emitted", 64'(awaited_terms.size()), '0);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
